// ----- rtl/core/pba_pkg.sv -----
`timescale 1ns / 1ps

package pba_pkg;

    localparam int PAGE_COUNT  = 4096;
    localparam int WORD_BITS   = 32;
    localparam int WORD_COUNT  = PAGE_COUNT / WORD_BITS;
    localparam int WADDR_W     = $clog2(WORD_COUNT);
    localparam int OFS_W       = $clog2(WORD_BITS);
    localparam int PG_W        = 14;
    localparam int QUEUE_DEPTH = 2;

    localparam logic [2:0] ACT_ALLOC     = 3'd0;
    localparam logic [2:0] ACT_FREE      = 3'd1;
    localparam logic [2:0] ACT_MARK_USED = 3'd2;
    localparam logic [2:0] ACT_MARK_FREE = 3'd3;
    localparam logic [2:0] ACT_QUERY     = 3'd4;
    localparam logic [2:0] ACT_RELEASE   = 3'd5;

    localparam logic [1:0] STS_OK       = 2'd0;
    localparam logic [1:0] STS_NO_SPACE = 2'd1;
    localparam logic [1:0] STS_BAD_ARG  = 2'd2;

    typedef enum logic [1:0] {
        OP_ALLOC,
        OP_RANGE,
        OP_QUERY,
        OP_BAD
    } t_op;

    // lo/hi: page range [lo, hi) already clipped to the managed count
    typedef struct packed {
        t_op                op;
        logic               set;
        logic [PG_W-1:0]    lo;
        logic [PG_W-1:0]    hi;
        logic [PG_W-1:0]    amount;
        logic [PG_W-1:0]    align;
        logic [WORD_BITS-1:0] mask;
    } t_cmd;

    typedef struct packed {
        logic [1:0]  status;
        logic [11:0] first_page;
        logic        page_free;
    } t_result;

    typedef struct packed {
        logic pop;
        logic busy;
    } t_back_stat;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_DISPATCH,
        ST_CAND,
        ST_SCAN_RD,
        ST_SCAN_CHK,
        ST_ADV,
        ST_STEP,
        ST_RMW_RD,
        ST_RMW_WR,
        ST_QRY_RD,
        ST_QRY_CHK,
        ST_RESP
    } t_state;

endpackage

// ----- rtl/core/page_bitmap_allocator.sv -----
`timescale 1ns / 1ps
// Bad requests and marks or queries outside the page count are answered without touching
// the bitmap; a range free or release reads and writes each bitmap word it touches; alloc
// scans words, skips to the next aligned start past a used page, then marks the run's words.
// One request at a time runs in the bitmap engine; a 2-entry queue takes new requests
// meanwhile.
// Reset (synchronous, active low): all pages free via per-word valid flags, page count 4096.

module page_bitmap_allocator (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_s_tvalid,
    output logic        o_s_tready,
    // page[11:0], amount[24:12], alignment[37:25], word_index[44:38],
    // release_mask[76:45], zero[79:77]
    input  logic [79:0] i_s_tdata,
    // action[2:0]
    input  logic [2:0]  i_s_tuser,
    output logic        o_m_tvalid,
    input  logic        i_m_tready,
    // status[1:0], first_page[13:2], page_free[14], zero[15]
    output logic [15:0] o_m_tdata,
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic [12:0] i_cfg_data
);
    import pba_pkg::*;

    logic [12:0] r_pages_in_use;
    logic [12:0] managed;
    logic        q_push;
    logic        q_full;
    logic        q_empty;
    t_cmd        q_in;
    t_cmd        q_out;
    t_back_stat  back_stat;
    t_result     result;

    assign o_cfg_ready = 1'b1;
    assign managed     = (r_pages_in_use > 13'(PAGE_COUNT)) ? 13'(PAGE_COUNT)
                                                            : r_pages_in_use;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pages_in_use <= 13'(PAGE_COUNT);
        end else if (i_cfg_valid) begin
            r_pages_in_use <= i_cfg_data;
        end
    end

    pba_front u_front (
        .i_valid        (i_s_tvalid),
        .o_ready        (o_s_tready),
        .i_action       (i_s_tuser),
        .i_page         (i_s_tdata[11:0]),
        .i_amount       (i_s_tdata[24:12]),
        .i_alignment    (i_s_tdata[37:25]),
        .i_word_index   (i_s_tdata[44:38]),
        .i_release_mask (i_s_tdata[76:45]),
        .i_managed      (managed),
        .i_q_full       (q_full),
        .o_push         (q_push),
        .o_cmd          (q_in)
    );

    pba_fifo #(
        .DEPTH (QUEUE_DEPTH)
    ) u_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (q_push),
        .i_data  (q_in),
        .i_pop   (back_stat.pop),
        .o_data  (q_out),
        .o_full  (q_full),
        .o_empty (q_empty)
    );

    pba_back u_back (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_managed  (managed),
        .i_q_empty  (q_empty),
        .i_q_cmd    (q_out),
        .o_stat     (back_stat),
        .o_m_valid  (o_m_tvalid),
        .i_m_ready  (i_m_tready),
        .o_m_result (result)
    );

    assign o_m_tdata = {1'b0, result.page_free, result.first_page, result.status};

`ifndef NO_ASSERTIONS
    a_no_push_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        q_push |-> !q_full)
        else $error("transfer pushed into a full queue");

    a_no_pop_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        back_stat.pop |-> !q_empty && !back_stat.busy)
        else $error("engine popped an empty queue or while busy");

    a_free_only_ok: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_m_tvalid && o_m_tdata[14]) |-> (o_m_tdata[1:0] == STS_OK)
                                          && (o_m_tdata[13:2] == 12'd0))
        else $error("query answer with non-ok status or a page number");
`endif

endmodule

// ----- rtl/core/pba_ram.sv -----
`timescale 1ns / 1ps

module pba_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 128
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_q;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_q <= r_mem[i_raddr];
    end

    assign o_rdata = r_q;

endmodule

// ----- rtl/core/pba_front.sv -----
`timescale 1ns / 1ps

module pba_front (
    input  logic                  i_valid,
    output logic                  o_ready,
    input  logic [2:0]            i_action,
    input  logic [11:0]           i_page,
    input  logic [12:0]           i_amount,
    input  logic [12:0]           i_alignment,
    input  logic [6:0]            i_word_index,
    input  logic [31:0]           i_release_mask,
    input  logic [12:0]           i_managed,
    input  logic                  i_q_full,
    output logic                  o_push,
    output pba_pkg::t_cmd         o_cmd
);
    import pba_pkg::*;

    logic [PG_W-1:0] page_x;
    logic [PG_W-1:0] lim;
    logic [PG_W-1:0] end_x;
    logic [PG_W-1:0] wlo;
    logic [PG_W-1:0] wend;
    logic [PG_W-1:0] one_hi;

    assign page_x = {2'b00, i_page};
    assign lim    = {1'b0, i_managed};
    assign end_x  = page_x + {1'b0, i_amount};
    assign wlo    = {2'b00, i_word_index, 5'b00000};
    assign wend   = wlo + PG_W'(WORD_BITS);
    // single-page ops: empty range when the page is outside the managed count
    assign one_hi = (page_x < lim) ? page_x + PG_W'(1) : page_x;

    assign o_ready = !i_q_full;
    assign o_push  = i_valid && !i_q_full;

    always_comb begin
        o_cmd        = '0;
        o_cmd.op     = OP_BAD;
        o_cmd.lo     = page_x;
        o_cmd.hi     = page_x;
        o_cmd.amount = {1'b0, i_amount};
        o_cmd.align  = {1'b0, i_alignment};
        o_cmd.mask   = '1;
        case (i_action) inside
            ACT_ALLOC: begin
                if (i_amount == '0 || i_alignment == '0) begin
                    o_cmd.op = OP_BAD;
                end else begin
                    o_cmd.op = OP_ALLOC;
                end
            end
            ACT_FREE: begin
                o_cmd.op = OP_RANGE;
                o_cmd.hi = (end_x < lim) ? end_x : lim;
            end
            ACT_MARK_USED, ACT_MARK_FREE: begin
                o_cmd.op  = OP_RANGE;
                o_cmd.set = (i_action == ACT_MARK_USED);
                o_cmd.hi  = one_hi;
            end
            ACT_QUERY: begin
                o_cmd.op = OP_QUERY;
                o_cmd.hi = one_hi;
            end
            ACT_RELEASE: begin
                o_cmd.op   = OP_RANGE;
                o_cmd.lo   = wlo;
                o_cmd.hi   = (wend < lim) ? wend : lim;
                o_cmd.mask = i_release_mask;
            end
            default: begin
                o_cmd.op = OP_BAD;
            end
        endcase
    end

endmodule

// ----- rtl/core/pba_fifo.sv -----
`timescale 1ns / 1ps

module pba_fifo #(
    parameter int DEPTH = 2
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_push,
    input  pba_pkg::t_cmd i_data,
    input  logic          i_pop,
    output pba_pkg::t_cmd o_data,
    output logic          o_full,
    output logic          o_empty
);
    import pba_pkg::*;

    localparam int PTR_W = $clog2(DEPTH);
    localparam int CNT_W = $clog2(DEPTH + 1);

    t_cmd             r_mem [DEPTH];
    logic [PTR_W-1:0] r_wptr, n_wptr;
    logic [PTR_W-1:0] r_rptr, n_rptr;
    logic [CNT_W-1:0] r_cnt, n_cnt;

    assign o_full  = (r_cnt == CNT_W'(DEPTH));
    assign o_empty = (r_cnt == '0);
    assign o_data  = r_mem[r_rptr];

    always_comb begin
        n_wptr = r_wptr;
        n_rptr = r_rptr;
        n_cnt  = r_cnt;
        if (i_push) begin
            n_wptr = (r_wptr == PTR_W'(DEPTH - 1)) ? '0 : r_wptr + PTR_W'(1);
        end
        if (i_pop) begin
            n_rptr = (r_rptr == PTR_W'(DEPTH - 1)) ? '0 : r_rptr + PTR_W'(1);
        end
        if (i_push && !i_pop) begin
            n_cnt = r_cnt + CNT_W'(1);
        end else if (!i_push && i_pop) begin
            n_cnt = r_cnt - CNT_W'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wptr <= '0;
            r_rptr <= '0;
            r_cnt  <= '0;
        end else begin
            r_wptr <= n_wptr;
            r_rptr <= n_rptr;
            r_cnt  <= n_cnt;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wptr] <= i_data;
        end
    end

endmodule

// ----- rtl/core/pba_back.sv -----
`timescale 1ns / 1ps

module pba_back (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic [12:0]          i_managed,
    input  logic                 i_q_empty,
    input  pba_pkg::t_cmd        i_q_cmd,
    output pba_pkg::t_back_stat  o_stat,
    output logic                 o_m_valid,
    input  logic                 i_m_ready,
    output pba_pkg::t_result     o_m_result
);
    import pba_pkg::*;

    function automatic logic [5:0] rel_clamp(input logic [PG_W-1:0] hi,
                                             input logic [PG_W-1:0] base);
        logic [PG_W-1:0] d;
        d = hi - base;
        return (d >= PG_W'(WORD_BITS)) ? 6'(WORD_BITS) : d[5:0];
    endfunction

    // bits b with lo <= b < rel
    function automatic logic [WORD_BITS-1:0] win_mask(input logic [OFS_W-1:0] lo,
                                                     input logic [5:0] rel);
        logic [WORD_BITS-1:0] m;
        for (int b = 0; b < WORD_BITS; b++) begin
            m[b] = (6'(b) >= {1'b0, lo}) && (6'(b) < rel);
        end
        return m;
    endfunction

    function automatic logic [OFS_W-1:0] first_set(input logic [WORD_BITS-1:0] v);
        logic [OFS_W-1:0] idx;
        idx = '0;
        for (int b = WORD_BITS - 1; b >= 0; b--) begin
            if (v[b]) begin
                idx = OFS_W'(b);
            end
        end
        return idx;
    endfunction

    t_state              r_state, n_state;
    t_cmd                r_cmd, n_cmd;
    logic [PG_W-1:0]     r_pos, n_pos;
    logic [PG_W-1:0]     r_cand, n_cand;
    logic [PG_W-1:0]     r_u, n_u;
    logic [3:0]          r_k, n_k;
    t_result             r_res, n_res;
    t_result             r_out, n_out;
    logic                r_out_valid, n_out_valid;
    logic [WORD_COUNT-1:0] r_wvalid, n_wvalid;
    logic                r_rdv, n_rdv;

    logic                 ram_we;
    logic [WADDR_W-1:0]   ram_addr;
    logic [WORD_BITS-1:0] ram_wdata;
    logic [WORD_BITS-1:0] ram_q;

    logic [PG_W-1:0]      lim;
    logic [WORD_BITS-1:0] rd_word;
    logic [PG_W-1:0]      base;
    logic [PG_W-1:0]      next_base;
    logic [PG_W-1:0]      end_c;
    logic [WORD_BITS-1:0] scan_used;
    logic [WORD_BITS-1:0] rmw_m;
    logic [23:0]          step;
    logic [23:0]          adv_sum;
    logic                 adv_fit;
    logic                 cand_fail;
    logic                 out_free;

    pba_ram #(
        .WIDTH (WORD_BITS),
        .DEPTH (WORD_COUNT)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_addr),
        .i_wdata (ram_wdata),
        .i_raddr (ram_addr),
        .o_rdata (ram_q)
    );

    assign lim       = {1'b0, i_managed};
    // words never written read as all free
    assign rd_word   = r_rdv ? ram_q : '0;
    assign ram_addr  = r_pos[OFS_W +: WADDR_W];
    assign base      = {r_pos[PG_W-1:OFS_W], {OFS_W{1'b0}}};
    assign next_base = base + PG_W'(WORD_BITS);
    assign end_c     = r_cand + r_cmd.amount;
    assign scan_used = rd_word & win_mask(r_pos[OFS_W-1:0], rel_clamp(end_c, base));
    assign rmw_m     = win_mask(r_pos[OFS_W-1:0], rel_clamp(r_cmd.hi, base)) & r_cmd.mask;
    assign step      = {10'b0, r_cmd.align} << r_k;
    assign adv_sum   = {10'b0, r_cand} + step;
    assign adv_fit   = (adv_sum <= {10'b0, r_u});
    assign cand_fail = (r_cand >= lim) || (end_c > lim);
    assign out_free  = !r_out_valid || i_m_ready;

    always_comb begin
        n_state = r_state;
        case (r_state)
            ST_IDLE: begin
                if (!i_q_empty) begin
                    n_state = ST_DISPATCH;
                end
            end
            ST_DISPATCH: begin
                case (r_cmd.op)
                    OP_ALLOC: n_state = ST_CAND;
                    OP_RANGE: n_state = (r_cmd.lo >= r_cmd.hi) ? ST_RESP : ST_RMW_RD;
                    OP_QUERY: n_state = (r_cmd.lo >= r_cmd.hi) ? ST_RESP : ST_QRY_RD;
                    default:  n_state = ST_RESP;
                endcase
            end
            ST_CAND:     n_state = cand_fail ? ST_RESP : ST_SCAN_RD;
            ST_SCAN_RD:  n_state = ST_SCAN_CHK;
            ST_SCAN_CHK: begin
                if (scan_used != '0) begin
                    n_state = ST_ADV;
                end else if (next_base >= end_c) begin
                    n_state = ST_RMW_RD;
                end else begin
                    n_state = ST_SCAN_RD;
                end
            end
            ST_ADV:      n_state = (r_k == '0) ? ST_STEP : ST_ADV;
            ST_STEP:     n_state = ST_CAND;
            ST_RMW_RD:   n_state = ST_RMW_WR;
            ST_RMW_WR:   n_state = (next_base >= r_cmd.hi) ? ST_RESP : ST_RMW_RD;
            ST_QRY_RD:   n_state = ST_QRY_CHK;
            ST_QRY_CHK:  n_state = ST_RESP;
            ST_RESP: begin
                if (out_free) begin
                    n_state = ST_IDLE;
                end
            end
            default:     n_state = ST_IDLE;
        endcase
    end

    always_comb begin
        n_cmd       = r_cmd;
        n_pos       = r_pos;
        n_cand      = r_cand;
        n_u         = r_u;
        n_k         = r_k;
        n_res       = r_res;
        n_out       = r_out;
        n_out_valid = r_out_valid && !i_m_ready;
        n_wvalid    = r_wvalid;
        n_rdv       = r_rdv;
        ram_we      = 1'b0;
        ram_wdata   = '0;
        o_stat.pop  = 1'b0;
        o_stat.busy = (r_state != ST_IDLE);
        case (r_state)
            ST_IDLE: begin
                if (!i_q_empty) begin
                    o_stat.pop = 1'b1;
                    n_cmd      = i_q_cmd;
                    n_res      = '{status: STS_OK, first_page: '0, page_free: 1'b0};
                    n_cand     = '0;
                    n_pos      = i_q_cmd.lo;
                end
            end
            ST_DISPATCH: begin
                if (r_cmd.op == OP_BAD) begin
                    n_res.status = STS_BAD_ARG;
                end
            end
            ST_CAND: begin
                if (cand_fail) begin
                    n_res.status = STS_NO_SPACE;
                end
                n_pos = r_cand;
            end
            ST_SCAN_RD, ST_RMW_RD, ST_QRY_RD: begin
                n_rdv = r_wvalid[ram_addr];
            end
            ST_SCAN_CHK: begin
                if (scan_used != '0) begin
                    n_u = base + PG_W'(first_set(scan_used));
                    n_k = 4'd11;
                end else if (next_base >= end_c) begin
                    // whole run free: reuse the range writer to mark it used
                    n_pos            = r_cand;
                    n_cmd.hi         = end_c;
                    n_cmd.set        = 1'b1;
                    n_cmd.mask       = '1;
                    n_res.first_page = r_cand[11:0];
                end else begin
                    n_pos = next_base;
                end
            end
            ST_ADV: begin
                // greedy binary step: largest aligned start not past the used page
                if (adv_fit) begin
                    n_cand = adv_sum[PG_W-1:0];
                end
                n_k = r_k - 4'd1;
            end
            ST_STEP: begin
                n_cand = r_cand + r_cmd.align;
            end
            ST_RMW_WR: begin
                ram_we             = 1'b1;
                ram_wdata          = r_cmd.set ? (rd_word | rmw_m) : (rd_word & ~rmw_m);
                n_wvalid[ram_addr] = 1'b1;
                n_pos              = next_base;
            end
            ST_QRY_CHK: begin
                n_res.page_free = ~rd_word[r_pos[OFS_W-1:0]];
            end
            ST_RESP: begin
                if (out_free) begin
                    n_out_valid = 1'b1;
                    n_out       = r_res;
                end
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_out_valid <= 1'b0;
            r_wvalid    <= '0;
            r_rdv       <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
            r_wvalid    <= n_wvalid;
            r_rdv       <= n_rdv;
        end
    end

    always_ff @(posedge i_clk) begin
        r_cmd  <= n_cmd;
        r_pos  <= n_pos;
        r_cand <= n_cand;
        r_u    <= n_u;
        r_k    <= n_k;
        r_res  <= n_res;
        r_out  <= n_out;
    end

    assign o_m_valid  = r_out_valid;
    assign o_m_result = r_out;

endmodule
